/* rtl/bild_pkg.sv */
// Shared types and constants for the branch instruction length decoder.
package bild_pkg;

    localparam int MAX_LENGTH = 15;
    localparam int LEN_W      = 4;
    localparam int SUM_W      = 5;

    // Legacy prefixes and the REX range
    localparam logic [7:0] PFX_ES     = 8'h26;
    localparam logic [7:0] PFX_CS     = 8'h2E;
    localparam logic [7:0] PFX_SS     = 8'h36;
    localparam logic [7:0] PFX_DS     = 8'h3E;
    localparam logic [7:0] PFX_FS     = 8'h64;
    localparam logic [7:0] PFX_GS     = 8'h65;
    localparam logic [7:0] PFX_OPSIZE = 8'h66;
    localparam logic [7:0] PFX_ADSIZE = 8'h67;
    localparam logic [7:0] PFX_LOCK   = 8'hF0;
    localparam logic [7:0] PFX_REPNE  = 8'hF2;
    localparam logic [7:0] PFX_REP    = 8'hF3;
    localparam logic [7:0] REX_FIRST  = 8'h40;
    localparam logic [7:0] REX_LAST   = 8'h4F;

    // Branch opcodes
    localparam logic [7:0] OP_JCC_SHORT_FIRST = 8'h70;
    localparam logic [7:0] OP_JCC_SHORT_LAST  = 8'h7F;
    localparam logic [7:0] OP_JMP_SHORT       = 8'hEB;
    localparam logic [7:0] OP_JCXZ            = 8'hE3;
    localparam logic [7:0] OP_CALL_REL        = 8'hE8;
    localparam logic [7:0] OP_JMP_REL         = 8'hE9;
    localparam logic [7:0] OP_ESCAPE          = 8'h0F;
    localparam logic [7:0] OP_GROUP5          = 8'hFF;
    localparam logic [7:0] OP_JCC_NEAR_FIRST  = 8'h80;
    localparam logic [7:0] OP_JCC_NEAR_LAST   = 8'h8F;

    // modrm / sib fields for the FF group
    localparam logic [1:0] MOD_MEM       = 2'd0;
    localparam logic [1:0] MOD_DISP8     = 2'd1;
    localparam logic [1:0] MOD_DISP32    = 2'd2;
    localparam logic [1:0] MOD_REG       = 2'd3;
    localparam logic [2:0] FF_CALL_NEAR  = 3'd2;
    localparam logic [2:0] FF_JMP_FAR    = 3'd5;
    localparam logic [2:0] RM_SIB        = 3'd4;
    localparam logic [2:0] RM_RIP        = 3'd5;
    localparam logic [2:0] SIB_BASE_NONE = 3'd5;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NOT_BRANCH = 2'd1,
        ST_TOO_LONG   = 2'd2
    } t_status;

    typedef struct packed {
        logic             valid;
        logic [LEN_W-1:0] len;
        t_status          status;
    } t_result;

endpackage

/* rtl/bild_core.sv */
// Decode state and combinational step logic for one code byte.
module bild_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_byte,
    input  logic              i_first,
    output bild_pkg::t_result o_res
);
    import bild_pkg::*;

    typedef enum logic [4:0] {
        PH_IDLE    = 5'b00001,
        PH_PREFIX  = 5'b00010,
        PH_TWOBYTE = 5'b00100,
        PH_MODRM   = 5'b01000,
        PH_SIB     = 5'b10000
    } t_phase;

    function automatic logic is_prefix(input logic [7:0] b);
        return b == PFX_ES || b == PFX_CS || b == PFX_SS || b == PFX_DS ||
               b == PFX_FS || b == PFX_GS || b == PFX_OPSIZE || b == PFX_ADSIZE ||
               b == PFX_LOCK || b == PFX_REPNE || b == PFX_REP ||
               (b >= REX_FIRST && b <= REX_LAST);
    endfunction

    function automatic logic [SUM_W-1:0] disp_size(input logic [1:0] mode);
        unique case (mode)
            MOD_DISP8:  return SUM_W'(1);
            MOD_DISP32: return SUM_W'(4);
            default:    return '0;
        endcase
    endfunction

    t_phase           r_phase, n_phase;
    logic [LEN_W-1:0] r_count, n_count;
    logic [7:0]       r_modrm, n_modrm;

    t_phase           ph;
    logic [LEN_W-1:0] p;
    logic [SUM_W-1:0] p_ext;
    logic [SUM_W-1:0] rlen;
    logic             fin;
    t_status          st;
    logic [1:0]       mode;
    logic [2:0]       regf;
    logic [2:0]       rm;

    always_comb begin
        ph      = i_first ? PH_PREFIX : r_phase;
        p       = i_first ? '0 : r_count;
        p_ext   = {1'b0, p};
        n_phase = ph;
        n_count = p;
        n_modrm = r_modrm;
        rlen    = '0;
        fin     = 1'b0;
        st      = ST_OK;
        mode    = i_byte[7:6];
        regf    = i_byte[5:3];
        rm      = i_byte[2:0];

        unique case (ph)
            PH_PREFIX: begin
                if (is_prefix(i_byte)) begin
                    n_count = p + LEN_W'(1);
                    if ((p_ext + SUM_W'(3)) > SUM_W'(MAX_LENGTH)) begin
                        fin = 1'b1;
                        st  = ST_TOO_LONG;
                    end
                end else if (i_byte == OP_JMP_SHORT || i_byte == OP_JCXZ ||
                             (i_byte >= OP_JCC_SHORT_FIRST &&
                              i_byte <= OP_JCC_SHORT_LAST)) begin
                    fin  = 1'b1;
                    rlen = p_ext + SUM_W'(2);
                end else if (i_byte == OP_CALL_REL || i_byte == OP_JMP_REL) begin
                    fin  = 1'b1;
                    rlen = p_ext + SUM_W'(5);
                end else if (i_byte == OP_ESCAPE) begin
                    n_phase = PH_TWOBYTE;
                end else if (i_byte == OP_GROUP5) begin
                    n_phase = PH_MODRM;
                end else begin
                    fin = 1'b1;
                    st  = ST_NOT_BRANCH;
                end
            end
            PH_TWOBYTE: begin
                fin = 1'b1;
                if (i_byte >= OP_JCC_NEAR_FIRST && i_byte <= OP_JCC_NEAR_LAST) begin
                    rlen = p_ext + SUM_W'(6);
                end else begin
                    st = ST_NOT_BRANCH;
                end
            end
            PH_MODRM: begin
                n_modrm = i_byte;
                if (regf < FF_CALL_NEAR || regf > FF_JMP_FAR) begin
                    fin = 1'b1;
                    st  = ST_NOT_BRANCH;
                end else if (mode == MOD_REG) begin
                    fin  = 1'b1;
                    rlen = p_ext + SUM_W'(2);
                end else if (rm == RM_SIB) begin
                    n_phase = PH_SIB;
                end else begin
                    fin  = 1'b1;
                    rlen = p_ext + SUM_W'(2) + disp_size(mode) +
                           ((mode == MOD_MEM && rm == RM_RIP) ? SUM_W'(4) : '0);
                end
            end
            PH_SIB: begin
                fin  = 1'b1;
                rlen = p_ext + SUM_W'(3) + disp_size(r_modrm[7:6]) +
                       ((r_modrm[7:6] == MOD_MEM && i_byte[2:0] == SIB_BASE_NONE) ?
                        SUM_W'(4) : '0);
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase

        // Flag lengths past the architectural limit.
        if (fin && st == ST_OK && rlen > SUM_W'(MAX_LENGTH)) begin
            st = ST_TOO_LONG;
        end
        if (fin) begin
            n_phase = PH_IDLE;
        end

        o_res.valid  = fin;
        o_res.status = st;
        o_res.len    = (st == ST_OK) ? rlen[LEN_W-1:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_count <= '0;
            r_modrm <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_modrm <= n_modrm;
        end
    end

    a_idle_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_res.valid) |=> r_phase == PH_IDLE)
        else $error("decoder not idle after a result");

    a_error_zero_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.status != ST_OK) |-> o_res.len == '0)
        else $error("nonzero length with error status");

    a_ok_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.status == ST_OK) |->
        (o_res.len >= LEN_W'(2) && o_res.len <= LEN_W'(MAX_LENGTH)))
        else $error("ok length out of range");

    // The prefix that overflows the limit is still counted before going idle.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= LEN_W'(MAX_LENGTH - 1)))
        else $error("prefix count beyond limit");

endmodule

/* rtl/branch_instruction_length_decoder_top.sv */
// Top level: input register, byte decoder and result register.
//
//  channel | valid       | stall        | payload
//  --------+-------------+--------------+--------------------------------
//  in      | i_in_valid  | o_in_stall   | i_code_byte, i_first_byte
//  out     | o_out_valid | i_out_stall  | o_total_length, o_status
//
// One byte per cycle sustained unless a stalled result holds the input side;
// a byte waits in the input register and its result (if any) is written to the
// result register when the decoder steps it; the decode logic is combinational.
// Reset (synchronous, active low) empties both registers and idles the decoder.
// A stalled result only holds the input side when the waiting byte completes
// an instruction; bytes that give no result keep flowing.
module branch_instruction_length_decoder_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [7:0]                   i_code_byte,
    input  logic                         i_first_byte,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [bild_pkg::LEN_W-1:0]   o_total_length,
    output logic [1:0]                   o_status
);
    import bild_pkg::*;

    logic             r_in_valid;
    logic [7:0]       r_byte;
    logic             r_first;
    logic             r_out_valid;
    logic [LEN_W-1:0] r_len;
    t_status          r_status;

    t_result res;
    logic    out_free;
    logic    step;
    logic    in_acc;

    bild_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_byte),
        .i_first (r_first),
        .o_res   (res)
    );

    assign out_free   = !r_out_valid || !i_out_stall;
    assign step       = r_in_valid && (!res.valid || out_free);
    assign o_in_stall = r_in_valid && !step;
    assign in_acc     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_acc) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_byte  <= i_code_byte;
            r_first <= i_first_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && res.valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Load a new result only when the old one is gone or leaving.
    always_ff @(posedge i_clk) begin
        if (step && res.valid) begin
            r_len    <= res.len;
            r_status <= res.status;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_total_length = r_len;
    assign o_status       = r_status;

    a_result_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && res.valid) |=> r_out_valid)
        else $error("result transaction lost");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !(step && res.valid))
        else $error("pending result overwritten");

endmodule
